@@ rtl/zone_map_range_pruner_defines.svh @@
// assertion macros for the zone map range pruner checker
// no dependencies; included by zmrp_checker, the file that carries the concurrent assertions
`ifndef ZONE_MAP_RANGE_PRUNER_DEFINES_SVH
`define ZONE_MAP_RANGE_PRUNER_DEFINES_SVH

// checked only outside reset
`define ZMRP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ZMRP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/zmrp_pkg.sv @@
`timescale 1ns / 1ps
// shared widths, codes and types of the zone map range pruner
// no dependencies; imported by every other file of the block but the assertion defines header
package zmrp_pkg;

  // significant key bits, 8 to 64; key fields stay 64 bits wide
  localparam int KEY_BITS = 64;
  localparam int KEY_W    = 64;
  localparam int PAGE_W   = 32;
  localparam int RCNT_W   = 32;
  localparam int PSUM_W   = 48;
  localparam int REASON_W = 3;

  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REASON_W-1:0] REASON_PRUNED       = 3'd0;
  localparam logic [REASON_W-1:0] REASON_NO_VERSION   = 3'd1;
  localparam logic [REASON_W-1:0] REASON_NO_SECURITY  = 3'd2;
  localparam logic [REASON_W-1:0] REASON_META_MISSING = 3'd3;
  localparam logic [REASON_W-1:0] REASON_STALE        = 3'd4;
  localparam logic [REASON_W-1:0] REASON_INCOMPATIBLE = 3'd5;
  localparam logic [REASON_W-1:0] REASON_NO_BOUNDS    = 3'd6;
  localparam logic [REASON_W-1:0] REASON_NO_PROOF     = 3'd7;

  localparam logic [REG_IDX_W-1:0] REG_LOWER_KEY    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_KEY    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_EN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_EN     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_INCL   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_INCL   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_VERSION_PLAN = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SECURE_PLAN  = 3'd7;

  typedef struct packed {
    logic [KEY_W-1:0] lower_bound_key;
    logic [KEY_W-1:0] upper_bound_key;
    logic             lower_enable;
    logic             upper_enable;
    logic             lower_incl;
    logic             upper_incl;
    logic             version_recheck_planned;
    logic             security_recheck_planned;
  } cfg_t;

  // classified range on its way from front to back
  typedef struct packed {
    logic                pruned;
    logic [REASON_W-1:0] reason_code;
    logic [PAGE_W-1:0]   page_span;
  } cls_t;

endpackage

@@ rtl/zmrp_ifs.sv @@
`timescale 1ns / 1ps
// request and result channels of the zone map range pruner
// depends on zmrp_pkg for field widths
interface zmrp_range_if;
  import zmrp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  range_min_key;
  logic [KEY_W-1:0]  range_max_key;
  logic              min_known;
  logic              max_known;
  logic              min_incl;
  logic              max_incl;
  logic              type_conflict;
  logic              meta_present;
  logic              meta_current;
  logic              pred_compatible;
  logic [PAGE_W-1:0] page_span;

  modport source (
    output valid, range_min_key, range_max_key, min_known, max_known, min_incl,
           max_incl, type_conflict, meta_present, meta_current, pred_compatible,
           page_span,
    input  ready
  );

  modport sink (
    input  valid, range_min_key, range_max_key, min_known, max_known, min_incl,
           max_incl, type_conflict, meta_present, meta_current, pred_compatible,
           page_span,
    output ready
  );
endinterface

interface zmrp_result_if;
  import zmrp_pkg::*;

  logic                valid;
  logic                ready;
  logic                pruned;
  logic [REASON_W-1:0] reason_code;
  logic [RCNT_W-1:0]   ranges_pruned_total;
  logic [RCNT_W-1:0]   ranges_scanned_total;
  logic [PSUM_W-1:0]   pages_pruned_total;
  logic [PSUM_W-1:0]   pages_scanned_total;
  logic                any_pruned_flag;

  modport source (
    output valid, pruned, reason_code, ranges_pruned_total, ranges_scanned_total,
           pages_pruned_total, pages_scanned_total, any_pruned_flag,
    input  ready
  );

  modport sink (
    input  valid, pruned, reason_code, ranges_pruned_total, ranges_scanned_total,
           pages_pruned_total, pages_scanned_total, any_pruned_flag,
    output ready
  );
endinterface

@@ rtl/zmrp_front.sv @@
`timescale 1ns / 1ps
// front end: takes range requests and classifies them against the predicate
// depends on zmrp_pkg and zmrp_range_if; feeds zmrp_queue
module zmrp_front (
  zmrp_range_if.sink      ranges,
  input  zmrp_pkg::cfg_t  cfg,
  input  logic            full,
  output logic            push,
  output zmrp_pkg::cls_t  cls
);
  import zmrp_pkg::*;

  logic [KEY_BITS-1:0] kmin;
  logic [KEY_BITS-1:0] kmax;
  logic [KEY_BITS-1:0] lo;
  logic [KEY_BITS-1:0] hi;
  logic                below_lower;
  logic                above_upper;
  logic                excluded;

  assign kmin = ranges.range_min_key[KEY_BITS-1:0];
  assign kmax = ranges.range_max_key[KEY_BITS-1:0];
  assign lo   = cfg.lower_bound_key[KEY_BITS-1:0];
  assign hi   = cfg.upper_bound_key[KEY_BITS-1:0];

  // a touching end only excludes when one side is open
  assign below_lower = (kmax < lo) ||
                       ((kmax == lo) && (!ranges.max_incl || !cfg.lower_incl));
  assign above_upper = (kmin > hi) ||
                       ((kmin == hi) && (!ranges.min_incl || !cfg.upper_incl));
  assign excluded    = (cfg.lower_enable && below_lower) ||
                       (cfg.upper_enable && above_upper);

  always_comb begin
    cls.pruned    = 1'b0;
    cls.page_span = ranges.page_span;
    priority if (!cfg.version_recheck_planned) begin
      cls.reason_code = REASON_NO_VERSION;
    end else if (!cfg.security_recheck_planned) begin
      cls.reason_code = REASON_NO_SECURITY;
    end else if (!ranges.meta_present) begin
      cls.reason_code = REASON_META_MISSING;
    end else if (!ranges.meta_current) begin
      cls.reason_code = REASON_STALE;
    end else if (!ranges.pred_compatible) begin
      cls.reason_code = REASON_INCOMPATIBLE;
    end else if (!ranges.min_known || !ranges.max_known) begin
      cls.reason_code = REASON_NO_BOUNDS;
    end else if (!ranges.type_conflict && excluded) begin
      cls.pruned      = 1'b1;
      cls.reason_code = REASON_PRUNED;
    end else begin
      cls.reason_code = REASON_NO_PROOF;
    end
  end

  assign ranges.ready = !full;
  assign push         = ranges.valid && !full;

endmodule

@@ rtl/zmrp_queue.sv @@
`timescale 1ns / 1ps
// short queue of classified ranges between front and back
// depends on zmrp_pkg
module zmrp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  zmrp_pkg::cls_t  din,
  input  logic            pop,
  output zmrp_pkg::cls_t  dout,
  output logic            full,
  output logic            empty
);
  import zmrp_pkg::*;

  cls_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/zmrp_back.sv @@
`timescale 1ns / 1ps
// back end: saturating totals and the registered result
// depends on zmrp_pkg and zmrp_result_if; drains zmrp_queue
module zmrp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  zmrp_pkg::cls_t  head,
  output logic            pop,
  zmrp_result_if.source   results
);
  import zmrp_pkg::*;

  logic                out_valid;
  logic                pruned;
  logic [REASON_W-1:0] reason_code;
  logic [RCNT_W-1:0]   pruned_range_count;
  logic [RCNT_W-1:0]   scanned_range_count;
  logic [PSUM_W-1:0]   pruned_page_sum;
  logic [PSUM_W-1:0]   scanned_page_sum;
  logic                seen_prune;

  logic [RCNT_W-1:0]   range_count_next;
  logic [PSUM_W:0]     page_sum_wide;
  logic [PSUM_W-1:0]   page_sum_next;

  assign pop = !empty && (!out_valid || results.ready);

  // one range counter and one page sum move per item, so share the adders
  always_comb begin
    logic [RCNT_W-1:0] rcnt;
    logic [PSUM_W-1:0] psum;
    rcnt = head.pruned ? pruned_range_count : scanned_range_count;
    psum = head.pruned ? pruned_page_sum : scanned_page_sum;
    range_count_next = (rcnt == '1) ? rcnt : rcnt + 1'b1;
    page_sum_wide    = {1'b0, psum} + {{(PSUM_W + 1 - PAGE_W){1'b0}}, head.page_span};
    page_sum_next    = page_sum_wide[PSUM_W] ? '1 : page_sum_wide[PSUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid           <= 1'b0;
      pruned_range_count  <= '0;
      scanned_range_count <= '0;
      pruned_page_sum     <= '0;
      scanned_page_sum    <= '0;
      seen_prune          <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head.pruned) begin
          pruned_range_count <= range_count_next;
          pruned_page_sum    <= page_sum_next;
          seen_prune         <= 1'b1;
        end else begin
          scanned_range_count <= range_count_next;
          scanned_page_sum    <= page_sum_next;
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pruned      <= head.pruned;
      reason_code <= head.reason_code;
    end
  end

  // totals only move when a new result loads, so they serve as the payload
  assign results.valid                = out_valid;
  assign results.pruned               = pruned;
  assign results.reason_code          = reason_code;
  assign results.ranges_pruned_total  = pruned_range_count;
  assign results.ranges_scanned_total = scanned_range_count;
  assign results.pages_pruned_total   = pruned_page_sum;
  assign results.pages_scanned_total  = scanned_page_sum;
  assign results.any_pruned_flag      = seen_prune;

endmodule

@@ rtl/zone_map_range_pruner.sv @@
`timescale 1ns / 1ps
// zone map range pruner: one range descriptor in, one pruning result out
// an accepted request goes through the queue write, then the output register
// one request per cycle unless results.ready stalls; classify is combinational
// rst is synchronous: clears predicate registers, totals, queue and result valid
// depends on zmrp_pkg, zmrp_ifs, zmrp_front, zmrp_queue, zmrp_back
module zone_map_range_pruner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [zmrp_pkg::ADDR_W-1:0]   paddr,
  input  logic [zmrp_pkg::DATA_W-1:0]   pwdata,
  output logic [zmrp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  zmrp_range_if.sink                    ranges,
  zmrp_result_if.source                 results
);
  import zmrp_pkg::*;

  cfg_t                 cfg;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  logic push;
  logic pop;
  logic full;
  logic empty;
  cls_t cls;
  cls_t head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LOWER_KEY:    cfg.lower_bound_key          <= pwdata[KEY_W-1:0];
        REG_UPPER_KEY:    cfg.upper_bound_key          <= pwdata[KEY_W-1:0];
        REG_LOWER_EN:     cfg.lower_enable             <= pwdata[0];
        REG_UPPER_EN:     cfg.upper_enable             <= pwdata[0];
        REG_LOWER_INCL:   cfg.lower_incl               <= pwdata[0];
        REG_UPPER_INCL:   cfg.upper_incl               <= pwdata[0];
        REG_VERSION_PLAN: cfg.version_recheck_planned  <= pwdata[0];
        REG_SECURE_PLAN:  cfg.security_recheck_planned <= pwdata[0];
        default:          cfg                          <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOWER_KEY:    prdata = DATA_W'(cfg.lower_bound_key);
      REG_UPPER_KEY:    prdata = DATA_W'(cfg.upper_bound_key);
      REG_LOWER_EN:     prdata = {{(DATA_W-1){1'b0}}, cfg.lower_enable};
      REG_UPPER_EN:     prdata = {{(DATA_W-1){1'b0}}, cfg.upper_enable};
      REG_LOWER_INCL:   prdata = {{(DATA_W-1){1'b0}}, cfg.lower_incl};
      REG_UPPER_INCL:   prdata = {{(DATA_W-1){1'b0}}, cfg.upper_incl};
      REG_VERSION_PLAN: prdata = {{(DATA_W-1){1'b0}}, cfg.version_recheck_planned};
      REG_SECURE_PLAN:  prdata = {{(DATA_W-1){1'b0}}, cfg.security_recheck_planned};
      default:          prdata = '0;
    endcase
  end

  zmrp_front u_front (
    .ranges (ranges),
    .cfg    (cfg),
    .full   (full),
    .push   (push),
    .cls    (cls)
  );

  zmrp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cls),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  zmrp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

@@ rtl/zmrp_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the zone map range pruner result channel
// depends on zmrp_pkg and zone_map_range_pruner_defines.svh; bound to the top level
`include "zone_map_range_pruner_defines.svh"

module zmrp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          pruned,
  input logic [zmrp_pkg::REASON_W-1:0] reason_code,
  input logic [zmrp_pkg::RCNT_W-1:0]   ranges_pruned_total,
  input logic [zmrp_pkg::PSUM_W-1:0]   pages_pruned_total,
  input logic                          any_pruned_flag
);
  import zmrp_pkg::*;

  `ZMRP_ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !res_valid, "result valid right after reset")

  `ZMRP_ASSERT(a_stall_holds, clk, rst, res_valid && !res_ready |=> res_valid && $stable(pruned) && $stable(reason_code) && $stable(ranges_pruned_total), "stalled result changed")

  `ZMRP_ASSERT(a_pruned_code, clk, rst, res_valid |-> (pruned == (reason_code == REASON_PRUNED)), "pruned flag and reason code disagree")

  `ZMRP_ASSERT(a_flag_sticky, clk, rst, any_pruned_flag |=> any_pruned_flag, "any pruned flag dropped")

  `ZMRP_ASSERT(a_totals_grow, clk, rst, 1'b1 |=> (ranges_pruned_total >= $past(ranges_pruned_total)) && (pages_pruned_total >= $past(pages_pruned_total)), "pruned totals went down")

endmodule

bind zone_map_range_pruner zmrp_checker u_zmrp_checker (
  .clk                 (clk),
  .rst                 (rst),
  .res_valid           (results.valid),
  .res_ready           (results.ready),
  .pruned              (results.pruned),
  .reason_code         (results.reason_code),
  .ranges_pruned_total (results.ranges_pruned_total),
  .pages_pruned_total  (results.pages_pruned_total),
  .any_pruned_flag     (results.any_pruned_flag)
);

@@ verif/tb_zone_map_range_pruner.sv @@
`timescale 1ns / 1ps
// self-checking bench for the zone map range pruner: apb predicate setup, range requests
// with bursty sends and a stalling receiver, checked against an in-bench scoreboard
// depends on zmrp_pkg, zmrp_ifs and the zone_map_range_pruner rtl
module tb_zone_map_range_pruner;
  import zmrp_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam int FULL_RATE_ITEMS = 60;

  typedef struct packed {
    logic [KEY_W-1:0]  range_min_key, range_max_key;
    logic              min_known, max_known, min_incl, max_incl;
    logic              type_conflict, meta_present, meta_current, pred_compatible;
    logic [PAGE_W-1:0] page_span;
  } range_req_t;

  typedef struct packed {
    logic                pruned;
    logic [REASON_W-1:0] reason_code;
    logic [RCNT_W-1:0]   ranges_pruned_total, ranges_scanned_total;
    logic [PSUM_W-1:0]   pages_pruned_total, pages_scanned_total;
    logic                any_pruned_flag;
  } prune_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  class range_pruning_board;
    cfg_t              predicate;
    logic [RCNT_W-1:0] pruned_ranges, scanned_ranges;
    logic [PSUM_W-1:0] pruned_pages, scanned_pages;
    logic              seen_prune;
    prune_result_t     awaited[$];
    int unsigned       errors, checked;
    bit [7:0]          reasons_hit;

    function new();
      predicate = '0;
      pruned_ranges = '0;
      scanned_ranges = '0;
      pruned_pages = '0;
      scanned_pages = '0;
      seen_prune = 1'b0;
      errors = 0;
      checked = 0;
      reasons_hit = '0;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_LOWER_KEY:    predicate.lower_bound_key = value;
        REG_UPPER_KEY:    predicate.upper_bound_key = value;
        REG_LOWER_EN:     predicate.lower_enable = value[0];
        REG_UPPER_EN:     predicate.upper_enable = value[0];
        REG_LOWER_INCL:   predicate.lower_incl = value[0];
        REG_UPPER_INCL:   predicate.upper_incl = value[0];
        REG_VERSION_PLAN: predicate.version_recheck_planned = value[0];
        REG_SECURE_PLAN:  predicate.security_recheck_planned = value[0];
        default: ;
      endcase
    endfunction

    // a touching end only keeps the range when both sides are inclusive
    function bit outside_predicate(logic [KEY_W-1:0] kmin, logic [KEY_W-1:0] kmax,
                                   logic min_incl, logic max_incl);
      logic [KEY_W-1:0] lo, hi;
      lo = predicate.lower_bound_key & KEY_MASK;
      hi = predicate.upper_bound_key & KEY_MASK;
      if (predicate.lower_enable) begin
        if (kmax < lo) return 1'b1;
        if (kmax == lo && !(max_incl && predicate.lower_incl)) return 1'b1;
      end
      if (predicate.upper_enable) begin
        if (kmin > hi) return 1'b1;
        if (kmin == hi && !(min_incl && predicate.upper_incl)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [PSUM_W-1:0] add_pages(logic [PSUM_W-1:0] acc, logic [PAGE_W-1:0] pages);
      logic [PSUM_W:0] sum;
      sum = {1'b0, acc} + (PSUM_W + 1)'(pages);
      return sum[PSUM_W] ? {PSUM_W{1'b1}} : sum[PSUM_W-1:0];
    endfunction

    function void note_request(range_req_t r);
      prune_result_t want;
      want = '0;
      if (!predicate.version_recheck_planned) begin
        want.reason_code = REASON_NO_VERSION;
      end else if (!predicate.security_recheck_planned) begin
        want.reason_code = REASON_NO_SECURITY;
      end else if (!r.meta_present) begin
        want.reason_code = REASON_META_MISSING;
      end else if (!r.meta_current) begin
        want.reason_code = REASON_STALE;
      end else if (!r.pred_compatible) begin
        want.reason_code = REASON_INCOMPATIBLE;
      end else if (!r.min_known || !r.max_known) begin
        want.reason_code = REASON_NO_BOUNDS;
      end else if (!r.type_conflict && outside_predicate(r.range_min_key & KEY_MASK,
                   r.range_max_key & KEY_MASK, r.min_incl, r.max_incl)) begin
        want.pruned = 1'b1;
        want.reason_code = REASON_PRUNED;
      end else begin
        want.reason_code = REASON_NO_PROOF;
      end
      if (want.pruned) begin
        if (pruned_ranges != {RCNT_W{1'b1}}) pruned_ranges = pruned_ranges + 1'b1;
        pruned_pages = add_pages(pruned_pages, r.page_span);
        seen_prune = 1'b1;
      end else begin
        if (scanned_ranges != {RCNT_W{1'b1}}) scanned_ranges = scanned_ranges + 1'b1;
        scanned_pages = add_pages(scanned_pages, r.page_span);
      end
      want.ranges_pruned_total = pruned_ranges;
      want.ranges_scanned_total = scanned_ranges;
      want.pages_pruned_total = pruned_pages;
      want.pages_scanned_total = scanned_pages;
      want.any_pruned_flag = seen_prune;
      awaited = {awaited, want};
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 25) begin
          $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(prune_result_t got);
      prune_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request outstanding, expected none actual 0x%0h",
                 $time, got);
        return;
      end
      want = awaited.pop_front();
      checked++;
      reasons_hit[want.reason_code] = 1'b1;
      match_field("pruned", 64'(want.pruned), 64'(got.pruned));
      match_field("reason_code", 64'(want.reason_code), 64'(got.reason_code));
      match_field("ranges_pruned_total", 64'(want.ranges_pruned_total),
                  64'(got.ranges_pruned_total));
      match_field("ranges_scanned_total", 64'(want.ranges_scanned_total),
                  64'(got.ranges_scanned_total));
      match_field("pages_pruned_total", 64'(want.pages_pruned_total),
                  64'(got.pages_pruned_total));
      match_field("pages_scanned_total", 64'(want.pages_scanned_total),
                  64'(got.pages_scanned_total));
      match_field("any_pruned_flag", 64'(want.any_pruned_flag), 64'(got.any_pruned_flag));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              pready;

  zmrp_range_if  ranges ();
  zmrp_result_if results ();

  zone_map_range_pruner dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ranges  (ranges),
    .results (results)
  );

  range_pruning_board board;
  bit                 full_rate = 1'b0;
  int unsigned        burst_left = 0;
  int unsigned        settings = 0;
  stall_mode_e        stall_mode = STALL_NONE;
  int unsigned        stall_hold = 0;
  logic [31:0]        tick = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver back-pressure, switching to a new random stall pattern after each random hold
  always @(posedge clk) begin
    tick <= tick + 1;
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_hold <= $urandom_range(16, 120);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    if (rst || full_rate) begin
      results.ready <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:     results.ready <= 1'b1;
        STALL_COIN:     results.ready <= 1'($urandom_range(0, 1));
        STALL_HEAVY:    results.ready <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: results.ready <= (tick[2:0] != 3'd0);
        default:        results.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      board.check_result(prune_result_t'{results.pruned, results.reason_code,
                                         results.ranges_pruned_total,
                                         results.ranges_scanned_total,
                                         results.pages_pruned_total,
                                         results.pages_scanned_total,
                                         results.any_pruned_flag});
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    board.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic send_range(input range_req_t r);
    ranges.valid <= 1'b1;
    ranges.range_min_key <= r.range_min_key;
    ranges.range_max_key <= r.range_max_key;
    ranges.min_known <= r.min_known;
    ranges.max_known <= r.max_known;
    ranges.min_incl <= r.min_incl;
    ranges.max_incl <= r.max_incl;
    ranges.type_conflict <= r.type_conflict;
    ranges.meta_present <= r.meta_present;
    ranges.meta_current <= r.meta_current;
    ranges.pred_compatible <= r.pred_compatible;
    ranges.page_span <= r.page_span;
    @(posedge clk);
    while (!ranges.ready) @(posedge clk);
    board.note_request(r);
  endtask

  // sender bursts: keep valid up until the burst runs out, then idle a while
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      ranges.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 30);
    end
  endtask

  // predicate registers only change with the pipe empty
  task automatic drain();
    ranges.valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] flag_word(logic b);
    logic [DATA_W-1:0] w;
    w = {$urandom, $urandom};
    w[0] = b;
    return w;
  endfunction

  function automatic logic [KEY_W-1:0] any_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return KEY_W'($urandom_range(0, 255));
      3:       return ~KEY_W'($urandom_range(0, 255));
      4:       return {1'b1, 31'($urandom), 32'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] near_key(logic [KEY_W-1:0] anchor);
    logic [KEY_W-1:0] d;
    d = KEY_W'($urandom_range(0, 4));
    return anchor + d - KEY_W'(2);
  endfunction

  function automatic range_req_t plain_range(logic [KEY_W-1:0] kmin, logic [KEY_W-1:0] kmax,
                                             logic min_incl, logic max_incl,
                                             logic [PAGE_W-1:0] pages);
    range_req_t r;
    r = '0;
    r.range_min_key = kmin;
    r.range_max_key = kmax;
    r.min_known = 1'b1;
    r.max_known = 1'b1;
    r.min_incl = min_incl;
    r.max_incl = max_incl;
    r.meta_present = 1'b1;
    r.meta_current = 1'b1;
    r.pred_compatible = 1'b1;
    r.page_span = pages;
    return r;
  endfunction

  // keys cluster around the bounds so touching ends come up often
  function automatic range_req_t random_range();
    range_req_t       r;
    logic [KEY_W-1:0] a, b, t, lo, hi;
    lo = board.predicate.lower_bound_key;
    hi = board.predicate.upper_bound_key;
    case ($urandom_range(0, 3))
      0: begin a = near_key(lo); b = near_key(lo); end
      1: begin a = near_key(hi); b = near_key(hi); end
      2: begin a = near_key(lo); b = near_key(hi); end
      default: begin a = any_key(); b = any_key(); end
    endcase
    if (a > b && $urandom_range(0, 7) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    r = plain_range(a, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
    case ($urandom_range(0, 7))
      0: r.page_span = '0;
      1: r.page_span = '1;
      default: ;
    endcase
    if ($urandom_range(0, 6) == 0) begin
      {r.min_known, r.max_known, r.type_conflict, r.meta_present, r.meta_current,
       r.pred_compatible} = 6'($urandom);
    end else begin
      r.type_conflict = ($urandom_range(0, 15) == 0);
    end
    return r;
  endfunction

  task automatic apply_setting(input int phase);
    logic [KEY_W-1:0] lo, hi, t;
    logic [5:0]       flags;
    case (phase)
      0: begin lo = '0; hi = '1; flags = 6'b111111; end
      1: begin lo = '1; hi = '0; flags = 6'b110011; end
      default: begin
        lo = any_key();
        hi = any_key();
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          t = lo;
          lo = hi;
          hi = t;
        end
        flags = {$urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0, 4'($urandom)};
      end
    endcase
    drain();
    write_reg(REG_LOWER_KEY, lo);
    write_reg(REG_UPPER_KEY, hi);
    write_reg(REG_LOWER_EN, flag_word(flags[3]));
    write_reg(REG_UPPER_EN, flag_word(flags[2]));
    write_reg(REG_LOWER_INCL, flag_word(flags[1]));
    write_reg(REG_UPPER_INCL, flag_word(flags[0]));
    write_reg(REG_VERSION_PLAN, flag_word(flags[5]));
    write_reg(REG_SECURE_PLAN, flag_word(flags[4]));
    settings++;
  endtask

  initial begin
    range_req_t r;
    board = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    ranges.valid <= 1'b0;
    ranges.range_min_key <= '0;
    ranges.range_max_key <= '0;
    ranges.min_known <= 1'b0;
    ranges.max_known <= 1'b0;
    ranges.min_incl <= 1'b0;
    ranges.max_incl <= 1'b0;
    ranges.type_conflict <= 1'b0;
    ranges.meta_present <= 1'b0;
    ranges.meta_current <= 1'b0;
    ranges.pred_compatible <= 1'b0;
    ranges.page_span <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // out of reset no recheck is planned, so everything is scanned
    r = '1;
    send_range(r);
    r = '0;
    send_range(r);
    drain();
    write_reg(REG_VERSION_PLAN, flag_word(1'b1));
    send_range(plain_range(64'd10, 64'd50, 1'b1, 1'b1, 32'd3));

    drain();
    write_reg(REG_SECURE_PLAN, flag_word(1'b1));
    write_reg(REG_LOWER_KEY, 64'd100);
    write_reg(REG_UPPER_KEY, 64'd200);
    write_reg(REG_LOWER_EN, flag_word(1'b1));
    write_reg(REG_UPPER_EN, flag_word(1'b1));
    write_reg(REG_LOWER_INCL, flag_word(1'b1));
    write_reg(REG_UPPER_INCL, flag_word(1'b1));
    settings += 3;
    r = plain_range(64'd10, 64'd50, 1'b1, 1'b1, 32'd5);
    r.meta_present = 1'b0;
    send_range(r);
    r = plain_range(64'd10, 64'd50, 1'b1, 1'b1, 32'd5);
    r.meta_current = 1'b0;
    send_range(r);
    r = plain_range(64'd10, 64'd50, 1'b1, 1'b1, 32'd5);
    r.pred_compatible = 1'b0;
    send_range(r);
    r = plain_range(64'd10, 64'd50, 1'b1, 1'b1, 32'd5);
    r.min_known = 1'b0;
    send_range(r);
    r = plain_range(64'd10, 64'd50, 1'b1, 1'b1, 32'd5);
    r.max_known = 1'b0;
    send_range(r);
    r = plain_range(64'd10, 64'd50, 1'b1, 1'b1, 32'd5);
    r.type_conflict = 1'b1;
    send_range(r);
    send_range(plain_range(64'd10, 64'd50, 1'b1, 1'b1, 32'd9));
    send_range(plain_range(64'd10, 64'd100, 1'b1, 1'b1, 32'd9));
    send_range(plain_range(64'd10, 64'd100, 1'b1, 1'b0, 32'd9));
    send_range(plain_range(64'd200, 64'd300, 1'b1, 1'b1, 32'd9));
    send_range(plain_range(64'd200, 64'd300, 1'b0, 1'b1, 32'd9));
    send_range(plain_range(64'd201, '1, 1'b1, 1'b1, '1));
    send_range(plain_range(64'd120, 64'd150, 1'b1, 1'b1, 32'd2));
    send_range(plain_range('0, '1, 1'b1, 1'b1, '0));
    drain();
    write_reg(REG_LOWER_INCL, flag_word(1'b0));
    write_reg(REG_UPPER_INCL, flag_word(1'b0));
    send_range(plain_range(64'd10, 64'd100, 1'b1, 1'b1, 32'd4));
    send_range(plain_range(64'd200, 64'd300, 1'b1, 1'b1, 32'd4));
    drain();
    write_reg(REG_LOWER_EN, flag_word(1'b0));
    write_reg(REG_UPPER_EN, flag_word(1'b0));
    send_range(plain_range(64'd10, 64'd50, 1'b0, 1'b0, 32'd4));
    settings += 2;

    for (int phase = 0; phase < 7; phase++) begin
      apply_setting(phase);
      repeat (230) begin
        send_range(random_range());
        pace();
      end
    end

    // back-to-back maximum page spans with the receiver always ready
    drain();
    write_reg(REG_VERSION_PLAN, flag_word(1'b0));
    full_rate = 1'b1;
    repeat (FULL_RATE_ITEMS) begin
      r = random_range();
      r.page_span = '1;
      send_range(r);
    end
    drain();
    write_reg(REG_VERSION_PLAN, flag_word(1'b1));
    write_reg(REG_SECURE_PLAN, flag_word(1'b1));
    write_reg(REG_LOWER_KEY, '1);
    write_reg(REG_LOWER_EN, flag_word(1'b1));
    write_reg(REG_LOWER_INCL, flag_word(1'b0));
    write_reg(REG_UPPER_EN, flag_word(1'b0));
    repeat (FULL_RATE_ITEMS) begin
      send_range(plain_range(KEY_W'($urandom), KEY_W'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), '1));
    end
    settings += 2;
    drain();
    full_rate = 1'b0;
    repeat (8) @(posedge clk);

    $display("%0d range results checked under %0d predicate settings, %0d of 8 reason codes",
             board.checked, settings, $countones(board.reasons_hit));
    $display("bursty and back-to-back traffic with maximum page spans; %0d field mismatches",
             board.errors);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results still outstanding", board.awaited.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
